// File: design/olst_pkg.sv
package olst_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_IN_W = 5;
   localparam int FPOS_W   = 4;
   localparam int CNT_OUT_W = 5;

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_FIND   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   // what every cell does in the current cycle
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cell_ctl_type;

   // carried from cell to cell, front to back
   typedef struct packed {
      logic               hit_seen;
      logic signed [31:0] rd_data;
      logic [3:0]         fpos;
   } chain_type;

endpackage

// File: design/olst_cell.sv
module olst_cell #(
   parameter int W     = 5,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  olst_pkg::cell_ctl_type ctl,
   input  logic [W-1:0]          pos,
   input  logic [W-1:0]          count,
   input  logic signed [31:0]    left_entry,
   input  logic signed [31:0]    right_entry,
   output logic signed [31:0]    entry,
   input  olst_pkg::chain_type   chain_in,
   output olst_pkg::chain_type   chain_out
);

   localparam logic [W-1:0] MY_IDX = W'(INDEX);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               in_list;
   logic               hit;
   logic               first_hit;
   logic               sel;

   assign entry     = entry_ff;
   assign in_list   = MY_IDX < count;
   assign sel       = MY_IDX == pos;
   assign hit       = in_list && (entry_ff == ctl.value);
   assign first_hit = hit && !chain_in.hit_seen;

   // pass the search and read results on toward the back
   always_comb begin
      chain_out.hit_seen = chain_in.hit_seen | hit;
      chain_out.rd_data  = chain_in.rd_data | (sel ? entry_ff : 32'sd0);
      chain_out.fpos     = chain_in.fpos | (first_hit ? MY_IDX[3:0] : 4'd0);
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         olst_pkg::OP_INSERT: begin
            if (MY_IDX > pos) begin
               entry_in = left_entry;
            end else if (sel) begin
               entry_in = ctl.value;
            end
         end
         olst_pkg::OP_REMOVE: begin
            if (MY_IDX >= pos) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/ordered_list_store_top.sv
// Ordered list store: a bounded list of up to DEPTH signed 32-bit values,
// position 0 at the front.
// Input channel: an item (req_command, req_value, req_position) is taken at
// a rising edge where start is high and busy is low. busy stays low, so an
// item may be issued on every cycle.
// Result channel: every item gives exactly one result, shown on the rsp_
// ports for one cycle with rsp_valid high, in the cycle right after the
// item is taken. The receiver cannot stall, so nothing ever backs up.
// Throughput is one item per cycle for every command.
// The list sits in a row of DEPTH cells. Insert and remove shift the cells
// behind the position by one place in that same cycle; find and read run
// a match and select chain from the front cell to the back cell, which sets
// the cycle time as DEPTH grows.
// Reset (synchronous, active high) empties the list and drops any pending
// result; cell contents are not cleared and are never read past the count.
module ordered_list_store_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_data_out,
   output logic [3:0]         rsp_found_position,
   output logic               rsp_found,
   output logic [4:0]         rsp_entry_count,
   output logic [1:0]         rsp_error_code
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int W     = (CNT_W > olst_pkg::POS_IN_W) ? CNT_W : olst_pkg::POS_IN_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic               rsp_valid_ff;
   logic signed [31:0] data_ff,  data_in;
   logic [3:0]         fpos_ff,  fpos_in;
   logic               found_ff, found_in;
   logic [4:0]         cnt_out_ff;
   logic [1:0]         err_ff;
   olst_pkg::err_type  err_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [W-1:0]          cnt_ext;
   logic [W-1:0]          cnt_next_ext;
   logic [W-1:0]          pos_ext;
   logic [W-1:0]          cell_pos;
   olst_pkg::cell_ctl_type ctl;

   logic signed [31:0]  entry_w [DEPTH];
   olst_pkg::chain_type chain_w [DEPTH+1];

   // the block never holds off an item
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign cnt_ext = W'(count_ff);
   assign pos_ext = W'(req_position);

   // front of the chain: nothing seen yet
   assign chain_w[0] = '{hit_seen: 1'b0, rd_data: 32'sd0, fpos: 4'd0};

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [31:0] left_w;
         logic signed [31:0] right_w;
         if (gi == 0) begin : g_front
            assign left_w = req_value;
         end else begin : g_mid_l
            assign left_w = entry_w[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_back
            assign right_w = entry_w[gi];
         end else begin : g_mid_r
            assign right_w = entry_w[gi+1];
         end
         olst_cell #(
            .W     (W),
            .INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .pos         (cell_pos),
            .count       (cnt_ext),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[gi]),
            .chain_in    (chain_w[gi]),
            .chain_out   (chain_w[gi+1])
         );
      end
   endgenerate

   // decode the command, check it, and steer the cells
   always_comb begin
      ctl.op    = olst_pkg::OP_HOLD;
      ctl.value = req_value;
      cell_pos  = pos_ext;
      count_in  = count_ff;
      data_in   = 32'sd0;
      fpos_in   = 4'd0;
      found_in  = 1'b0;
      err_in    = olst_pkg::ERR_OK;
      case (olst_pkg::cmd_type'(req_command))
         olst_pkg::CMD_PUSH: begin
            cell_pos = '0;
            if (full) begin
               err_in = olst_pkg::ERR_FULL;
            end else begin
               ctl.op   = olst_pkg::OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         olst_pkg::CMD_POP: begin
            cell_pos = '0;
            if (empty) begin
               err_in = olst_pkg::ERR_EMPTY;
            end else begin
               ctl.op   = olst_pkg::OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
               data_in  = chain_w[DEPTH].rd_data;
            end
         end
         olst_pkg::CMD_INSERT: begin
            if (full) begin
               err_in = olst_pkg::ERR_FULL;
            end else if (pos_ext > cnt_ext) begin
               err_in = olst_pkg::ERR_RANGE;
            end else begin
               ctl.op   = olst_pkg::OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         olst_pkg::CMD_REMOVE: begin
            if (empty) begin
               err_in = olst_pkg::ERR_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               err_in = olst_pkg::ERR_RANGE;
            end else begin
               ctl.op   = olst_pkg::OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         olst_pkg::CMD_FIND: begin
            found_in = chain_w[DEPTH].hit_seen;
            fpos_in  = chain_w[DEPTH].fpos;
         end
         olst_pkg::CMD_READ: begin
            if (pos_ext >= cnt_ext) begin
               err_in = olst_pkg::ERR_RANGE;
            end else begin
               data_in = chain_w[DEPTH].rd_data;
            end
         end
         default: begin
            err_in = olst_pkg::ERR_OK;
         end
      endcase
      // drop any change when no item is taken
      if (!accept) begin
         ctl.op   = olst_pkg::OP_HOLD;
         count_in = count_ff;
      end
   end

   assign cnt_next_ext = W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload, loaded with every accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff    <= data_in;
         fpos_ff    <= fpos_in;
         found_ff   <= found_in;
         cnt_out_ff <= cnt_next_ext[4:0];
         err_ff     <= err_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = data_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_found          = found_ff;
   assign rsp_entry_count    = cnt_out_ff;
   assign rsp_error_code     = err_ff;

`ifndef SYNTHESIS
   // the list never holds more than DEPTH entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   // every taken item gives a result on the next cycle, and only then
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after accepted item");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept))
      else $error("result without accepted item");

   // a good pop leaves one entry fewer
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == olst_pkg::CMD_POP && !empty)
      |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not shrink the list");
`endif

endmodule
